// File: sv/twa_pkg.sv
// Package for the trimmed window average fan controller.
// Holds the shared field widths, register indexes, sequencer states and divider status.
// Depends on nothing.
package twa_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned SUM_OUT_W = 18;
  localparam int unsigned AVG_OUT_W = 20;
  localparam int unsigned HOLD_OUT_W = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned FRAC_W = 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_FAN_ON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUST_THRESH   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DUST_THRESH_RST = 18'd32738;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TRIM,
    ST_DIVIDE,
    ST_DELIVER
  } twa_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } twa_div_stat_t;

endpackage

// File: sv/twa_cell.sv
// One storage cell of the sample chain.
// Takes the value of its left neighbor when the chain moves; uses twa_pkg.
module twa_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic [twa_pkg::SAMPLE_W-1:0]  d_in,
  output logic [twa_pkg::SAMPLE_W-1:0]  q
);
  import twa_pkg::*;

  logic [SAMPLE_W-1:0] val_r;
  logic [SAMPLE_W-1:0] val_nxt;

  assign val_nxt = shift_en ? d_in : val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;

endmodule

// File: sv/twa_div.sv
// Constant divider for the Q8 average, built as a multiply by a scaled reciprocal.
// Registers the dividend on start, then registers the quotient with done; uses twa_pkg for the status struct.
module twa_div #(
  parameter int unsigned NUM_W   = 26,
  parameter int unsigned DIVISOR = 38
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [NUM_W-1:0]       dividend,
  output logic [NUM_W-1:0]       quotient,
  output twa_pkg::twa_div_stat_t stat
);
  import twa_pkg::*;

  // With the shift at NUM_W + clog2(DIVISOR) and the reciprocal rounded up, the
  // shifted product is the exact floor quotient for every NUM_W-bit dividend.
  localparam int unsigned SHIFT   = NUM_W + $clog2(DIVISOR);
  localparam int unsigned RECIP_W = NUM_W + 1;
  localparam int unsigned PROD_W  = NUM_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [NUM_W-1:0]  quot_r, quot_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(num_r) * PROD_W'(RECIP);

  always_comb begin
    num_nxt  = num_r;
    quot_nxt = quot_r;
    busy_nxt = 1'b0;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = dividend;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = NUM_W'(prod >> SHIFT);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
  end

  assign quotient  = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: sv/trimmed_window_average_fan_control.sv
// Top level of the trimmed window average fan controller.
// Builds on twa_pkg, the twa_cell sample chain and the twa_div divider.
//
// The block keeps the last WINDOW dust samples in a chain of cells that is all
// zero after reset. Each accepted request pushes its sample into the head of
// the chain and drops the oldest one. The chain is then rotated once all the
// way around, one cell per cycle, while a single accumulator at its tail builds
// the sum, the smallest and the largest entry. The trimmed sum (sum less one
// minimum and one maximum) feeds a constant divider that multiplies by a scaled
// reciprocal of WINDOW-2 and gives the trimmed average in Q8. In auto mode the
// fan starts when the trimmed sum is above dust_threshold_sum and then holds
// for HOLD_TICKS requests before it is judged again; in manual mode it follows
// manual_fan_on. One request passes through the accepting idle state, the chain
// walk over all WINDOW cells, the trim state, the divider and the deliver state
// before the next request is taken. Delivery waits only while the previous
// result still waits for out_ready, so the chain walk sets the rate. A new
// request is taken while the previous result still waits in the output register.
// Configuration must be written only while the block is idle; the block itself
// does not enforce it.
module trimmed_window_average_fan_control #(
  parameter int unsigned WINDOW     = 40,
  parameter int unsigned HOLD_TICKS = 300
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [twa_pkg::SAMPLE_W-1:0]       in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [twa_pkg::SUM_OUT_W-1:0]      out_trimmed_sum,
  output logic [twa_pkg::AVG_OUT_W-1:0]      out_average_q8,
  output logic                               out_fan_on,
  output logic [twa_pkg::HOLD_OUT_W-1:0]     out_hold_count,
  input  logic                               cfg_we,
  input  logic [twa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import twa_pkg::*;

  // Internal widths follow the parameters but never drop below the port widths.
  localparam int unsigned SUM_CALC_W = $clog2(WINDOW * 4095 + 1);
  localparam int unsigned SUM_W  = (SUM_CALC_W > SUM_OUT_W) ? SUM_CALC_W : SUM_OUT_W;
  localparam int unsigned NUM_W  = SUM_W + FRAC_W;
  localparam int unsigned WCNT_W = $clog2(WINDOW);
  localparam int unsigned HOLD_CALC_W = $clog2(HOLD_TICKS + 2);
  localparam int unsigned HOLD_W = (HOLD_CALC_W > HOLD_OUT_W) ? HOLD_CALC_W : HOLD_OUT_W;

  // Configuration registers.
  logic                  auto_mode_r;
  logic                  manual_fan_on_r;
  logic [CFG_DATA_W-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_mode_r     <= 1'b0;
      manual_fan_on_r <= 1'b1;
      thresh_r        <= DUST_THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_MODE:     auto_mode_r     <= cfg_wdata[0];
        CFG_MANUAL_FAN_ON: manual_fan_on_r <= cfg_wdata[0];
        CFG_DUST_THRESH:   thresh_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer.
  twa_state_t state_r, state_nxt;
  logic [WCNT_W-1:0] walk_cnt_r, walk_cnt_nxt;
  logic              walk_last;
  logic              out_valid_r;
  logic              out_free;
  logic              in_load;
  logic              chain_shift;
  logic              acc_clear;
  logic              acc_en;
  logic              trim_load;
  logic              out_load;
  twa_div_stat_t     div_stat;

  assign walk_last = (walk_cnt_r == WCNT_W'(WINDOW - 1));
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_WALK;
      ST_WALK:    if (walk_last) state_nxt = ST_TRIM;
      ST_TRIM:    state_nxt = ST_DIVIDE;
      ST_DIVIDE:  if (div_stat.done) state_nxt = ST_DELIVER;
      ST_DELIVER: if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    acc_en    = 1'b0;
    trim_load = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_ready  = 1'b1;
      ST_WALK:    acc_en    = 1'b1;
      ST_TRIM:    trim_load = 1'b1;
      ST_DIVIDE:  ;
      ST_DELIVER: out_load  = out_free;
      default:    ;
    endcase
  end

  assign in_load     = in_valid && in_ready;
  assign acc_clear   = in_load;
  assign chain_shift = in_load || acc_en;
  assign walk_cnt_nxt = acc_en ? walk_cnt_r + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      walk_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      walk_cnt_r <= walk_cnt_nxt;
    end
  end

  // Sample chain. The head takes the new sample on a request and the tail value
  // otherwise, so a walk of WINDOW moves brings every cell back to its place.
  logic [SAMPLE_W-1:0] cell_q [WINDOW];
  logic [SAMPLE_W-1:0] head_d;
  logic [SAMPLE_W-1:0] tail;

  assign tail   = cell_q[WINDOW-1];
  assign head_d = in_load ? in_sample : tail;

  for (genvar g = 0; g < WINDOW; g++) begin : g_chain
    if (g == 0) begin : g_head
      twa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (chain_shift),
        .d_in     (head_d),
        .q        (cell_q[g])
      );
    end else begin : g_body
      twa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (chain_shift),
        .d_in     (cell_q[g-1]),
        .q        (cell_q[g])
      );
    end
  end

  // Accumulator at the tail of the chain.
  logic [SUM_W-1:0]    tot_r, tot_nxt;
  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic [SUM_W-1:0]    trim_r;

  always_comb begin
    tot_nxt = tot_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (acc_clear) begin
      tot_nxt = '0;
      lo_nxt  = SAMPLE_MAX;
      hi_nxt  = '0;
    end else if (acc_en) begin
      tot_nxt = tot_r + SUM_W'(tail);
      if (tail < lo_r) lo_nxt = tail;
      if (tail > hi_r) hi_nxt = tail;
    end
  end

  always_ff @(posedge clk) begin
    tot_r <= tot_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    if (trim_load) begin
      trim_r <= tot_r - SUM_W'(lo_r) - SUM_W'(hi_r);
    end
  end

  // The divider starts in the same cycle the trimmed sum is registered, so it
  // takes the difference straight from the accumulator.
  logic [SUM_W-1:0] trim_calc;
  logic [NUM_W-1:0] quot;

  assign trim_calc = tot_r - SUM_W'(lo_r) - SUM_W'(hi_r);

  twa_div #(
    .NUM_W   (NUM_W),
    .DIVISOR (WINDOW - 2)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (trim_load),
    .dividend ({trim_calc, {FRAC_W{1'b0}}}),
    .quotient (quot),
    .stat     (div_stat)
  );

  // Fan control. The hold counter and fan state move once per request, in the
  // cycle the result enters the output register.
  logic              fan_r, fan_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic [HOLD_W-1:0] hold_inc;

  assign hold_inc = hold_r + 1'b1;

  always_comb begin
    fan_nxt  = fan_r;
    hold_nxt = hold_r;
    if (out_load) begin
      if (auto_mode_r) begin
        if (hold_r != '0) begin
          hold_nxt = (hold_inc > HOLD_W'(HOLD_TICKS)) ? '0 : hold_inc;
        end else if (trim_r > SUM_W'(thresh_r)) begin
          fan_nxt  = 1'b1;
          hold_nxt = HOLD_W'(1);
        end else begin
          fan_nxt = 1'b0;
        end
      end else begin
        fan_nxt = manual_fan_on_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_r  <= 1'b1;
      hold_r <= '0;
    end else begin
      fan_r  <= fan_nxt;
      hold_r <= hold_nxt;
    end
  end

  // Output register.
  logic [SUM_OUT_W-1:0]  out_sum_r;
  logic [AVG_OUT_W-1:0]  out_avg_r;
  logic                  out_fan_r;
  logic [HOLD_OUT_W-1:0] out_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum_r  <= trim_r[SUM_OUT_W-1:0];
      out_avg_r  <= quot[AVG_OUT_W-1:0];
      out_fan_r  <= fan_nxt;
      out_hold_r <= hold_nxt[HOLD_OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trimmed_sum = out_sum_r;
  assign out_average_q8  = out_avg_r;
  assign out_fan_on      = out_fan_r;
  assign out_hold_count  = out_hold_r;

`ifndef SYNTHESIS
  // A request always starts a full walk of the chain.
  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_WALK && walk_cnt_r == '0)
    else $error("request did not start a chain walk");

  // The hold counter never runs past the hold length.
  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r <= HOLD_W'(HOLD_TICKS))
    else $error("hold counter out of range");

  // The trimmed sum never exceeds WINDOW-2 full-scale samples.
  a_trim_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVIDE |-> trim_r <= SUM_W'((WINDOW - 2) * 4095))
    else $error("trimmed sum out of range");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIVIDE)
    else $error("divider finished outside the divide state");
`endif

endmodule

// File: tb/trimmed_window_average_fan_control_tb.sv
// Self-checking testbench for the trimmed window average fan controller.
// Depends on twa_pkg and the trimmed_window_average_fan_control RTL; needs nothing else.
// Directed tests cover the field extremes, register corners and output back-pressure, then random traffic follows.
module trimmed_window_average_fan_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twa_pkg::*;

  // These match the DUT parameters.
  localparam int unsigned WINDOW       = 40;
  localparam int unsigned HOLD_TICKS   = 300;
  localparam int unsigned TRIM_SUM_MAX = (WINDOW - 2) * 4095;
  // Index 3 is decoded by nobody, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // If nothing moves on either channel for this many cycles, the run is hung.
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned END_SETTLE   = 100;
  localparam int unsigned RANDOM_ITEMS = 1420;

  typedef struct {
    logic [SUM_OUT_W-1:0]  trimmed_sum;
    logic [AVG_OUT_W-1:0]  average_q8;
    logic                  fan_on;
    logic [HOLD_OUT_W-1:0] hold_count;
  } fan_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SUM_OUT_W-1:0]  out_trimmed_sum;
  logic [AVG_OUT_W-1:0]  out_average_q8;
  logic                  out_fan_on;
  logic [HOLD_OUT_W-1:0] out_hold_count;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  trimmed_window_average_fan_control #(
    .WINDOW     (WINDOW),
    .HOLD_TICKS (HOLD_TICKS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_trimmed_sum (out_trimmed_sum),
    .out_average_q8  (out_average_q8),
    .out_fan_on      (out_fan_on),
    .out_hold_count  (out_hold_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // 20 ns period. Stimulus moves on the falling edge, checks look at the rising edge.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the sample ring, the fan logic and the
  // three configuration registers.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]   ring_samples [WINDOW];
  int unsigned           ring_next;
  int unsigned           hold_ticks_seen;
  logic                  fan_running;
  logic                  cfg_auto;
  logic                  cfg_manual_on;
  logic [CFG_DATA_W-1:0] cfg_threshold;

  // Results that the DUT still owes us, oldest first.
  fan_result_t pending_results[$];

  // Bookkeeping for the run summary and the verdict.
  int unsigned mismatches;
  int unsigned samples_sent;
  int unsigned results_checked;
  int unsigned settings_written;
  int unsigned fan_switches;
  int unsigned hold_expiries;
  int unsigned quiet_cycles;

  // Idling knobs. Each side draws a fresh random wait per request while its
  // knob is on; the long hold-off is counted by the receiver itself.
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned rx_gap_left;
  int unsigned rx_hold_req;
  int unsigned rx_hold_left;

  task automatic reset_predictor();
    foreach (ring_samples[k]) ring_samples[k] = '0;
    ring_next       = 0;
    hold_ticks_seen = 0;
    fan_running     = 1'b1;
    cfg_auto        = 1'b0;
    cfg_manual_on   = 1'b1;
    cfg_threshold   = DUST_THRESH_RST;
  endtask

  // Push one sample into the ring and work out the result the DUT must give.
  // The fan logic runs on the sum that already includes the new sample.
  function automatic fan_result_t predict_fan_result(input logic [SAMPLE_W-1:0] smp);
    fan_result_t     r;
    longint unsigned total;
    longint unsigned trimmed;
    longint unsigned avg;
    int unsigned     lo;
    int unsigned     hi;
    logic            fan_was;
    ring_samples[ring_next] = smp;
    ring_next = (ring_next + 1) % WINDOW;
    total = 0;
    lo    = SAMPLE_MAX;
    hi    = 0;
    foreach (ring_samples[k]) begin
      total += ring_samples[k];
      if (ring_samples[k] < lo) lo = ring_samples[k];
      if (ring_samples[k] > hi) hi = ring_samples[k];
    end
    // Exactly one smallest and one largest entry are dropped, even when ties exist.
    trimmed = total - lo - hi;
    avg     = (trimmed << FRAC_W) / (WINDOW - 2);

    fan_was = fan_running;
    if (cfg_auto) begin
      if (hold_ticks_seen != 0) begin
        // While holding, the fan keeps its state whatever the sum does.
        hold_ticks_seen++;
        if (hold_ticks_seen > HOLD_TICKS) begin
          hold_ticks_seen = 0;
          hold_expiries++;
        end
      end else if (trimmed > cfg_threshold) begin
        fan_running     = 1'b1;
        hold_ticks_seen = 1;
      end else begin
        fan_running = 1'b0;
      end
    end else begin
      // Manual mode follows the register and leaves the hold counter frozen.
      fan_running = cfg_manual_on;
    end
    if (fan_running != fan_was) fan_switches++;

    r.trimmed_sum = SUM_OUT_W'(trimmed);
    r.average_q8  = AVG_OUT_W'(avg);
    r.fan_on      = fan_running;
    r.hold_count  = HOLD_OUT_W'(hold_ticks_seen);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Offer one request. If no gap is drawn, valid stays high straight from the
  // previous request, so it is only lowered when there really is a gap.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_fan_result(smp));
    samples_sent++;
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One-cycle register write. The predictor copy changes at the same edge.
  // Only called with the DUT drained, so no request sees a half-written setting.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_AUTO_MODE:     cfg_auto      = data[0];
      CFG_MANUAL_FAN_ON: cfg_manual_on = data[0];
      CFG_DUST_THRESH:   cfg_threshold = data;
      default: ;
    endcase
    settings_written++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly samples around a level with some spread, plus full-scale spikes,
  // dropouts and the odd uniform value so that min/max trimming gets exercised.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int level, input int spread);
    int          v;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return SAMPLE_MAX;
    if (pick < 4) return '0;
    if (pick < 6) return SAMPLE_W'($urandom_range(0, 4095));
    v = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  // Thresholds cluster around the trimmed sum the current level will give,
  // so the fan actually switches, with the range ends mixed in.
  function automatic logic [CFG_DATA_W-1:0] pick_threshold(input int level);
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'(TRIM_SUM_MAX);
      2: return DUST_THRESH_RST;
      3: return CFG_DATA_W'($urandom_range(0, 262143));
      default: begin
        v = level * int'(WINDOW - 2) + int'($urandom_range(0, 8000)) - 4000;
        if (v < 0) v = 0;
        if (v > int'(TRIM_SUM_MAX)) v = TRIM_SUM_MAX;
        return CFG_DATA_W'(v);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: decides out_ready on every falling edge. A long hold-off asked
  // for by a test takes priority over the per-result wait.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else if (rx_gap_left > 0) begin
      out_ready <= 1'b0;
      rx_gap_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: every accepted result is matched field by field against
  // the oldest prediction. A result with nothing owed is itself a failure.
  fan_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("Unexpected result: trimmed_sum %0d, average_q8 %0d, fan_on %0b, hold_count %0d",
               out_trimmed_sum, out_average_q8, out_fan_on, out_hold_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_trimmed_sum !== want.trimmed_sum) begin
          $error("trimmed_sum: expected %0d, got %0d", want.trimmed_sum, out_trimmed_sum);
          mismatches++;
        end
        if (out_average_q8 !== want.average_q8) begin
          $error("average_q8: expected %0d, got %0d", want.average_q8, out_average_q8);
          mismatches++;
        end
        if (out_fan_on !== want.fan_on) begin
          $error("fan_on: expected %0b, got %0b", want.fan_on, out_fan_on);
          mismatches++;
        end
        if (out_hold_count !== want.hold_count) begin
          $error("hold_count: expected %0d, got %0d", want.hold_count, out_hold_count);
          mismatches++;
        end
      end
      results_checked++;
      rx_gap_left = rx_idle_on ? $urandom_range(0, 11) : 0;
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("No handshake for %0d cycles, %0d results still owed",
                 quiet_cycles, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset the block is in manual mode with the fan on and
  // an all-zero ring. Walk the sample through its extremes and bit patterns.
  task automatic test_reset_state_extremes();
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h001);
    drain_results();
  endtask

  // The one-bit registers must only take bit 0 of the write data, and a
  // write to the undecoded index must leave every register alone.
  task automatic test_register_masking();
    write_reg(CFG_MANUAL_FAN_ON, 18'h3FFFE);
    send_sample(12'h800);
    send_sample(12'h7FF);
    drain_results();
    write_reg(CFG_UNUSED, '1);
    send_sample(SAMPLE_MAX);
    drain_results();
    write_reg(CFG_MANUAL_FAN_ON, 18'h00001);
    send_sample(12'h123);
    drain_results();
  endtask

  // Auto mode against both threshold ends: at the largest possible trimmed
  // sum the fan can never start; at zero it starts and begins its hold.
  task automatic test_auto_threshold_extremes();
    write_reg(CFG_AUTO_MODE, 18'h00001);
    write_reg(CFG_DUST_THRESH, CFG_DATA_W'(TRIM_SUM_MAX));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(12'hF0F);
    drain_results();
    write_reg(CFG_DUST_THRESH, '0);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(12'h3C3);
    drain_results();
    write_reg(CFG_DUST_THRESH, '1);
    send_sample(12'h0F0);
    drain_results();
    write_reg(CFG_AUTO_MODE, '0);
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  // back to back, so the output register and the engine fill and in_ready drops.
  task automatic test_output_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_req = 400;
    repeat (6) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
    drain_results();
    tx_idle_on = 1'b1;
  endtask

  // Random phases. Each phase drains the DUT, picks a new setting and a dust
  // level, then streams samples around that level. Auto mode kept on across
  // phases lets the hold counter run all the way to expiry; now and then the
  // sender stops mid-phase until every result is back.
  task automatic test_random_traffic(input int unsigned total);
    int unsigned sent;
    int unsigned phase_len;
    int          level;
    int          spread;
    logic [CFG_DATA_W-1:0] data;
    sent = 0;
    while (sent < total) begin
      drain_results();
      case ($urandom_range(0, 5))
        0: level = 0;
        1: level = 4095;
        default: level = $urandom_range(0, 4095);
      endcase
      spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 1500);

      data    = CFG_DATA_W'($urandom_range(0, 262143));
      data[0] = ($urandom_range(0, 4) != 0);
      write_reg(CFG_AUTO_MODE, data);
      if ($urandom_range(0, 1)) write_reg(CFG_MANUAL_FAN_ON, CFG_DATA_W'($urandom_range(0, 262143)));
      write_reg(CFG_DUST_THRESH, pick_threshold(level));
      if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 262143)));

      // Each side runs with no idling at all in about a quarter of the phases.
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);

      phase_len = $urandom_range(40, 250);
      for (int unsigned i = 0; i < phase_len && sent < total; i++) begin
        send_sample(pick_sample(level, spread));
        sent++;
        if ($urandom_range(0, 79) == 0) drain_results();
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  initial begin
    mismatches       = 0;
    samples_sent     = 0;
    results_checked  = 0;
    settings_written = 0;
    fan_switches     = 0;
    hold_expiries    = 0;
    quiet_cycles     = 0;
    rx_gap_left      = 0;
    rx_hold_req      = 0;
    rx_hold_left     = 0;
    reset_predictor();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state_extremes();
    test_register_masking();
    test_auto_threshold_extremes();
    test_output_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    // Everything is sent; wait for the last results, then keep the clock running
    // so the DUT can show any stray result it should not produce.
    drain_results();
    repeat (END_SETTLE) @(posedge clk);

    $display("Run covered %0d samples under %0d register writes, %0d results checked.",
             samples_sent, settings_written, results_checked);
    $display("The fan switched %0d times and the auto hold ran out %0d times.",
             fan_switches, hold_expiries);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
